// ===== rtl/core/model_probability_update_unit_assert.svh =====
// Assertion macros for the model probability update unit.
// Used by the top level; needs nothing else.
`ifndef MODEL_PROBABILITY_UPDATE_UNIT_ASSERT_SVH
`define MODEL_PROBABILITY_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define MPU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mpu_pkg.sv =====
// Package for the model probability update unit: field widths, beat types,
// status and register codes, and the microcode ROM. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpu_pkg;

	localparam int MAX_MODELS_DEF = 8;

	localparam int DENS_W     = 32;
	localparam int PROB_W     = 17;
	localparam int MIN_W      = 16;
	localparam int COUNT_W    = 4;
	localparam int IDX_OUT_W  = 3;
	localparam int PROD_W     = 48;  // UQ16.16 * UQ1.16 (at most one), below 2^48
	localparam int SUM_W      = 52;  // up to 15 products
	localparam int PSUM_W     = 20;  // up to 15 probabilities of at most one
	localparam int SQ_W       = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int STEP_W     = 5;
	localparam int UCODE_DEPTH = 2 ** STEP_W;

	localparam logic [PROB_W-1:0]  ONE_Q16     = 17'h10000;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd4;
	localparam logic [MIN_W-1:0]   MIN_RESET   = 16'd655;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODEL_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PROBABILITY = 2'd1;

	typedef enum logic [1:0] {
		ST_UPDATED  = 2'd0,
		ST_FLOORED  = 2'd1,
		ST_ZERO_SUM = 2'd2,
		ST_NO_MEAS  = 2'd3
	} status_t;

	typedef struct packed {
		logic [DENS_W-1:0] density;
		logic              last_model;
		logic              measurement_present;
	} item_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] model_index;
		logic [PROB_W-1:0]    probability;
		status_t              status;
		logic                 last_result;
	} result_t;

	// 65536 / n, truncated, for n = 1..15
	localparam logic [PROB_W-1:0] UNIFORM_Q16 [16] = '{
		17'd0,     17'd65536, 17'd32768, 17'd21845,
		17'd16384, 17'd13107, 17'd10922, 17'd9362,
		17'd8192,  17'd7281,  17'd6553,  17'd5957,
		17'd5461,  17'd5041,  17'd4681,  17'd4369
	};

	// datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_MEAS,
		OP_READ,
		OP_MUL,
		OP_ACC_SUM,
		OP_SUM_CHK,
		OP_DIV_POST,
		OP_POST_WR,
		OP_RN_CHK,
		OP_DIV_RN,
		OP_RN_WR,
		OP_EMIT,
		OP_CLEAR
	} uop_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_WAIT_GO,
		C_NO_MEAS,
		C_MORE,
		C_DIV_BUSY,
		C_SUM_ZERO,
		C_NO_RENORM
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE      = 5'd0;
	localparam step_t STEP_MEAS      = 5'd1;
	localparam step_t STEP_SUM_RD    = 5'd2;
	localparam step_t STEP_SUM_MUL   = 5'd3;
	localparam step_t STEP_SUM_ACC   = 5'd4;
	localparam step_t STEP_SUM_CHK   = 5'd5;
	localparam step_t STEP_POST_RD   = 5'd6;
	localparam step_t STEP_POST_MUL  = 5'd7;
	localparam step_t STEP_POST_DIV  = 5'd8;
	localparam step_t STEP_POST_WAIT = 5'd9;
	localparam step_t STEP_POST_WR   = 5'd10;
	localparam step_t STEP_RN_CHK    = 5'd11;
	localparam step_t STEP_RN_RD     = 5'd12;
	localparam step_t STEP_RN_DIV    = 5'd13;
	localparam step_t STEP_RN_WAIT   = 5'd14;
	localparam step_t STEP_RN_WR     = 5'd15;
	localparam step_t STEP_EMIT_RD   = 5'd16;
	localparam step_t STEP_EMIT_OUT  = 5'd17;
	localparam step_t STEP_DONE      = 5'd18;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// update program
	localparam ucode_t UCODE [UCODE_DEPTH] = '{
		STEP_IDLE:      '{OP_INIT,     C_WAIT_GO,   STEP_IDLE},
		STEP_MEAS:      '{OP_MEAS,     C_NO_MEAS,   STEP_EMIT_RD},
		STEP_SUM_RD:    '{OP_READ,     C_NEXT,      STEP_IDLE},
		STEP_SUM_MUL:   '{OP_MUL,      C_NEXT,      STEP_IDLE},
		STEP_SUM_ACC:   '{OP_ACC_SUM,  C_MORE,      STEP_SUM_RD},
		STEP_SUM_CHK:   '{OP_SUM_CHK,  C_SUM_ZERO,  STEP_EMIT_RD},
		STEP_POST_RD:   '{OP_READ,     C_NEXT,      STEP_IDLE},
		STEP_POST_MUL:  '{OP_MUL,      C_NEXT,      STEP_IDLE},
		STEP_POST_DIV:  '{OP_DIV_POST, C_NEXT,      STEP_IDLE},
		STEP_POST_WAIT: '{OP_NONE,     C_DIV_BUSY,  STEP_POST_WAIT},
		STEP_POST_WR:   '{OP_POST_WR,  C_MORE,      STEP_POST_RD},
		STEP_RN_CHK:    '{OP_RN_CHK,   C_NO_RENORM, STEP_EMIT_RD},
		STEP_RN_RD:     '{OP_READ,     C_NEXT,      STEP_IDLE},
		STEP_RN_DIV:    '{OP_DIV_RN,   C_NEXT,      STEP_IDLE},
		STEP_RN_WAIT:   '{OP_NONE,     C_DIV_BUSY,  STEP_RN_WAIT},
		STEP_RN_WR:     '{OP_RN_WR,    C_MORE,      STEP_RN_RD},
		STEP_EMIT_RD:   '{OP_READ,     C_NEXT,      STEP_IDLE},
		STEP_EMIT_OUT:  '{OP_EMIT,     C_MORE,      STEP_EMIT_RD},
		STEP_DONE:      '{OP_CLEAR,    C_JUMP,      STEP_IDLE},
		default:        '{OP_NONE,     C_JUMP,      STEP_IDLE}
	};

	// datapath status seen by the sequencer
	typedef struct packed {
		logic go;
		logic no_meas;
		logic more;
		logic div_busy;
		logic sum_zero;
		logic no_renorm;
	} seq_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/model_probability_update_unit.sv =====
// Top level of the model probability update unit: density and probability
// stores, datapath and configuration. Depends on mpu_pkg, mpu_seq, mpu_div
// and model_probability_update_unit_assert.svh.
//
// Usage. Densities arrive one beat per model, in model order, on item: a beat
// is taken at a clock edge with start high and busy low. A beat without
// last_model is stored and busy stays low, so such beats go one per cycle.
// The beat with last_model closes the frame; busy then rises while, for n
// models, the unit runs: with no measurement, only the result pass; with a
// zero sum, the sum pass and then the results; in a normal update, the sum
// pass, a posterior pass with one division per model, then the results;
// when floored, also a renormalization pass with a second division each.
// The shared divider takes 17 quotient steps per division.
// Results come as n strobes on result_valid, model 0 first, last_result on
// the final one; the receiver cannot stall them.
// Configuration beats on cfg_valid/cfg_ready are taken while busy is low.
// Reset sets four models (capped at MAX_MODELS) at uniform probability, a
// floor of 655 and an empty density frame.
`timescale 1ns / 1ps
`default_nettype none
`include "model_probability_update_unit_assert.svh"

module model_probability_update_unit #(
	parameter int MAX_MODELS = mpu_pkg::MAX_MODELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  mpu_pkg::item_t                 item,
	output logic                           result_valid,
	output mpu_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mpu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mpu_pkg::*;

	localparam int IDXW = $clog2(MAX_MODELS);
	localparam int LPW  = $clog2(MAX_MODELS + 1);
	localparam int EW   = (LPW > COUNT_W) ? LPW : COUNT_W;
	localparam logic [COUNT_W-1:0] COUNT_INIT =
		(MAX_MODELS < 4) ? COUNT_W'(MAX_MODELS) : COUNT_RESET;

	// stores
	logic [DENS_W-1:0] dens_mem [MAX_MODELS];
	logic [PROB_W-1:0] prob_mem [MAX_MODELS];
	logic [MAX_MODELS-1:0] dvalid_q;
	logic [MAX_MODELS-1:0] pvalid_q;

	// control state
	logic [COUNT_W-1:0] count_q;
	logic [MIN_W-1:0]   min_q;
	logic [LPW-1:0]     lp_q;
	logic [IDXW-1:0]    idx_q;
	status_t            status_q;
	logic               renorm_q;
	logic               res_valid_q;

	// datapath registers
	logic               meas_q;
	logic [DENS_W-1:0]  dens_rd_q;
	logic               dvld_rd_q;
	logic [PROB_W-1:0]  prob_rd_q;
	logic               pvld_rd_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PSUM_W-1:0]  psum_q;
	logic [SQ_W-1:0]    sq_q;
	result_t            result_q;

	// combinational
	uop_t               op;
	seq_flags_t         flags;
	logic               accept;
	logic               store_dens;
	logic               more;
	logic [IDXW-1:0]    idx_step;
	logic [DENS_W-1:0]  dens_eff;
	logic [PROB_W-1:0]  prob_eff;
	logic [PROB_W:0]    floor_sum;
	logic [PROB_W-1:0]  floor_val;
	logic               floored;
	logic [PROB_W-1:0]  post_val;
	logic               prob_we;
	logic [PROB_W-1:0]  prob_wdata;
	logic               div_start;
	logic               div_busy;
	logic [SUM_W-1:0]   div_num;
	logic [SUM_W-1:0]   div_den;
	logic [PROB_W-1:0]  div_quot;
	logic [COUNT_W-1:0] count_wr;

	// handshakes
	assign accept     = start && !busy;
	assign store_dens = accept && (EW'(lp_q) < EW'(count_q));
	assign cfg_ready  = !busy;

	// model loop control
	always_comb begin
		more     = (EW'(idx_q) != EW'(count_q - 4'd1));
		idx_step = more ? idx_q + 1'b1 : '0;
	end

	// read data, with never-written entries at their reset value
	always_comb begin
		dens_eff = dvld_rd_q ? dens_rd_q : '0;
		prob_eff = pvld_rd_q ? prob_rd_q : UNIFORM_Q16[count_q];
	end

	// floor value min + min^2, saturated at one
	always_comb begin
		floor_sum = (PROB_W + 1)'(min_q) + (PROB_W + 1)'(sq_q[SQ_W-1:MIN_W]);
		floor_val = (floor_sum > (PROB_W + 1)'(ONE_Q16)) ? ONE_Q16 : floor_sum[PROB_W-1:0];
		floored   = (div_quot < {1'b0, min_q});
		post_val  = floored ? floor_val : div_quot;
	end

	// probability store write port
	always_comb begin
		prob_we    = (op == OP_POST_WR) || (op == OP_RN_WR);
		prob_wdata = (op == OP_RN_WR) ? div_quot : post_val;
	end

	// divider operands
	always_comb begin
		div_start = (op == OP_DIV_POST) || (op == OP_DIV_RN);
		div_num   = (op == OP_DIV_RN) ? SUM_W'(prob_eff) : SUM_W'(prod_q);
		div_den   = (op == OP_DIV_RN) ? SUM_W'(psum_q) : sum_q;
	end

	// clamped model count on a register write
	always_comb begin
		count_wr = cfg_data[COUNT_W-1:0];
		if (count_wr == '0) begin
			count_wr = 4'd1;
		end else if (int'(count_wr) > MAX_MODELS) begin
			count_wr = COUNT_W'(MAX_MODELS);
		end
	end

	// sequencer flags
	always_comb begin
		flags.go        = accept && item.last_model;
		flags.no_meas   = !meas_q;
		flags.more      = more;
		flags.div_busy  = div_busy;
		flags.sum_zero  = (sum_q == '0);
		flags.no_renorm = !renorm_q || (psum_q == '0);
	end

	mpu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op),
		.busy   (busy)
	);

	mpu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_INIT;
			min_q       <= MIN_RESET;
			lp_q        <= '0;
			idx_q       <= '0;
			dvalid_q    <= '0;
			pvalid_q    <= '0;
			status_q    <= ST_UPDATED;
			renorm_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (op == OP_EMIT);

			// density load
			if (store_dens) begin
				dvalid_q[lp_q[IDXW-1:0]] <= 1'b1;
			end
			if (accept && (lp_q != LPW'(MAX_MODELS))) begin
				lp_q <= lp_q + 1'b1;
			end

			unique case (op)
				OP_INIT: begin
					idx_q    <= '0;
					renorm_q <= 1'b0;
				end
				OP_MEAS:    status_q <= ST_NO_MEAS;
				OP_ACC_SUM: idx_q <= idx_step;
				OP_SUM_CHK: status_q <= ST_ZERO_SUM;
				OP_POST_WR: begin
					idx_q           <= idx_step;
					pvalid_q[idx_q] <= 1'b1;
					if (floored) begin
						renorm_q <= 1'b1;
					end
				end
				OP_RN_CHK:  status_q <= renorm_q ? ST_FLOORED : ST_UPDATED;
				OP_RN_WR: begin
					idx_q           <= idx_step;
					pvalid_q[idx_q] <= 1'b1;
				end
				OP_EMIT:    idx_q <= idx_step;
				OP_CLEAR: begin
					dvalid_q <= '0;
					lp_q     <= '0;
				end
				default: ;
			endcase

			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODEL_COUNT) begin
					count_q  <= count_wr;
					pvalid_q <= '0;
					dvalid_q <= '0;
					lp_q     <= '0;
				end else if (cfg_index == REG_MIN_PROBABILITY) begin
					min_q <= cfg_data[MIN_W-1:0];
				end
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= item.measurement_present;
		end
		unique case (op)
			OP_INIT: begin
				sum_q  <= '0;
				psum_q <= '0;
			end
			OP_MUL:     prod_q <= PROD_W'(dens_eff) * PROD_W'(prob_eff);
			OP_ACC_SUM: sum_q <= sum_q + SUM_W'(prod_q);
			OP_SUM_CHK: sq_q <= min_q * min_q;
			OP_POST_WR: psum_q <= psum_q + PSUM_W'(post_val);
			OP_EMIT: begin
				result_q.model_index <= IDX_OUT_W'(idx_q);
				result_q.probability <= prob_eff;
				result_q.status      <= status_q;
				result_q.last_result <= !more;
			end
			default: ;
		endcase
	end

	// density store
	always_ff @(posedge clk) begin
		if (store_dens) begin
			dens_mem[lp_q[IDXW-1:0]] <= item.density;
		end
		if (op == OP_READ) begin
			dens_rd_q <= dens_mem[idx_q];
			dvld_rd_q <= dvalid_q[idx_q];
		end
	end

	// probability store
	always_ff @(posedge clk) begin
		if (prob_we) begin
			prob_mem[idx_q] <= prob_wdata;
		end
		if (op == OP_READ) begin
			prob_rd_q <= prob_mem[idx_q];
			pvld_rd_q <= pvalid_q[idx_q];
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

	// checks
	`MPU_ASSERT_IMPLIES(a_result_in_frame, clk, arst_n, result_valid, busy, "result outside a frame")
	`MPU_ASSERT_IMPLIES(a_div_free, clk, arst_n, div_start, !div_busy, "divider restarted while busy")
	`MPU_ASSERT_IMPLIES(a_updated_above_floor, clk, arst_n, result_valid && (result.status == ST_UPDATED), result.probability >= {1'b0, min_q}, "unfloored posterior below minimum")
	`MPU_ASSERT_NEXT(a_plain_beat_idle, clk, arst_n, start && !busy && !item.last_model, !busy, "busy after a non-final beat")

endmodule

`default_nettype wire

// ===== rtl/core/mpu_div.sv =====
// Shared restoring divider: floor(num * 65536 / den) for num <= den,
// one quotient bit per cycle. Depends on mpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpu_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mpu_pkg::SUM_W-1:0]  num,
	input  logic [mpu_pkg::SUM_W-1:0]  den,
	output logic                       busy,
	output logic [mpu_pkg::PROB_W-1:0] quot
);
	import mpu_pkg::*;

	localparam int REM_W = SUM_W + 1;
	localparam int CNT_W = $clog2(PROB_W + 1);

	logic [REM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  den_q;
	logic [PROB_W-1:0] q_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              first;
	logic              ge;
	logic [REM_W-1:0]  trial;
	logic [REM_W-1:0]  diff;

	// first step compares without a shift, the integer bit of the quotient
	always_comb begin
		first = (cnt_q == CNT_W'(PROB_W));
		trial = first ? rem_q : {rem_q[REM_W-2:0], 1'b0};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(PROB_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			q_q   <= {q_q[PROB_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = (q_q > ONE_Q16) ? ONE_Q16 : q_q;

endmodule

`default_nettype wire

// ===== rtl/core/mpu_seq.sv =====
// Microcode sequencer: step counter, control word ROM from mpu_pkg and
// conditional jumps on datapath flags. Depends on mpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpu_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  mpu_pkg::seq_flags_t flags,
	output mpu_pkg::uop_t       op,
	output logic                busy
);
	import mpu_pkg::*;

	step_t  step_q;
	step_t  step_nxt;
	ucode_t word;
	logic   take;

	assign word = UCODE[step_q];

	// jump decision
	always_comb begin
		unique case (word.cond)
			C_NEXT:      take = 1'b0;
			C_JUMP:      take = 1'b1;
			C_WAIT_GO:   take = !flags.go;
			C_NO_MEAS:   take = flags.no_meas;
			C_MORE:      take = flags.more;
			C_DIV_BUSY:  take = flags.div_busy;
			C_SUM_ZERO:  take = flags.sum_zero;
			C_NO_RENORM: take = flags.no_renorm;
			default:     take = 1'b1;
		endcase
		step_nxt = take ? word.target : step_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	// control outputs
	always_comb begin
		op   = word.op;
		busy = (step_q != STEP_IDLE);
	end

endmodule

`default_nettype wire
